[sv/lzcd_pkg.sv]
// Package: types, constants and the header magic for the chunked LZ decompressor.
`default_nettype none
package lzcd_pkg;

	localparam int LZCD_WINDOW_DEPTH  = 32768;
	localparam int LZCD_OUT_SIZE_BITS = 24;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_MAGIC    = 3'd1;
	localparam logic [2:0] ERR_OFFSET   = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW = 3'd3;
	localparam logic [2:0] ERR_TRUNC    = 3'd4;

	localparam logic [3:0] HDR_LAST      = 4'd15;
	localparam logic [3:0] HDR_SIZE_BASE = 4'd12;

	typedef enum logic [8:0] {
		PH_HEADER = 9'b000000001,
		PH_CHDR0  = 9'b000000010,
		PH_CHDR1  = 9'b000000100,
		PH_RAW    = 9'b000001000,
		PH_TOK0   = 9'b000010000,
		PH_MATCH1 = 9'b000100000,
		PH_MATCH2 = 9'b001000000,
		PH_LIT    = 9'b010000000,
		PH_STOP   = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte0;
		logic [7:0] out_byte1;
		logic [7:0] out_byte2;
		logic [7:0] out_byte3;
		logic [2:0] byte_count;
		logic       run_last;
		logic [2:0] error_code;
		logic       stream_done;
	} out_t;

	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] m;
		unique case (idx)
			3'd0: m = 8'h2e;
			3'd1: m = 8'h53;
			3'd2: m = 8'h51;
			3'd3: m = 8'h5a;
			3'd4: m = 8'h2e;
			3'd5: m = 8'h62;
			3'd6: m = 8'h6d;
			default: m = 8'h70;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

[sv/lzcd_window.sv]
// History window: single-port-write, registered-read memory with write-to-read forwarding.
`default_nettype none
module lzcd_window import lzcd_pkg::*; #(
	parameter int WINDOW_DEPTH = LZCD_WINDOW_DEPTH,
	parameter int AW = $clog2(WINDOW_DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [7:0]         rdata
);

	logic [7:0] mem [WINDOW_DEPTH];
	logic [7:0] mem_q;
	logic [7:0] fwd_data_q;
	logic       fwd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			mem_q      <= mem[raddr];
			fwd_data_q <= wdata;
		end
	end

	// a read of the entry being written this cycle takes the new byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (re) begin
			fwd_q <= we && (waddr == raddr);
		end
	end

	assign rdata = fwd_q ? fwd_data_q : mem_q;

endmodule
`default_nettype wire

[sv/lz_chunk_decompressor_top.sv]
// Top level: byte-serial chunked LZ77 decompressor with history window and packed output.
`default_nettype none
// Takes one compressed file byte per request and returns decoded bytes, up to four to a
// result. Header, chunk header and token bytes give no result unless decoding stops; a
// literal or raw byte gives one result. A match holds the input while its bytes are read
// one a cycle while the output is not stalled, from the registered-read window memory
// and written back at the write position, with forwarding when the source byte is the
// one just written. Output stall pauses the copy. The window needs no clearing pass.
// Errors and end of stream latch until reset and every later request is answered by one
// status result.
module lz_chunk_decompressor_top import lzcd_pkg::*; #(
	parameter int WINDOW_DEPTH  = LZCD_WINDOW_DEPTH,
	parameter int OUT_SIZE_BITS = LZCD_OUT_SIZE_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_t      out_data
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int OSB = OUT_SIZE_BITS;
	localparam logic [32:0] SIZE_LIM = (33'd1 << OSB) - 33'd1;
	localparam logic [AW:0] DEPTH_X = (AW + 1)'(WINDOW_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

	logic           big_q;
	phase_t         phase_q, ph_n;
	logic [2:0]     err_q, err_n;
	logic [3:0]     hidx_q, hidx_n;
	logic [31:0]    hsize_q, hsize_n;
	logic [OSB-1:0] osize_q, osize_n;
	logic [OSB-1:0] wp_q;
	logic [AW-1:0]  wptr_q;
	logic [15:0]    crem_q, crem_n;
	logic [7:0]     lrem_q, lrem_n;
	logic [7:0]     tf_q, tf_n;
	logic [7:0]     ts_q, ts_n;

	logic           copy_q;
	logic [7:0]     rem_rd_q, rem_wr_q;
	logic [AW-1:0]  raddr_q;
	logic           offz_q;
	logic           rvld_s1;

	logic [3:0][7:0] pack_q;
	logic [1:0]      pcnt_q;
	logic            out_valid_q;
	out_t            out_q;

	logic        out_free, acc, go;
	logic        lit_push, status_emit, copy_start;
	logic [7:0]  m_cnt;
	logic [14:0] m_off;
	logic        m_do;
	logic [7:0]  copy_n;
	logic [AW-1:0] copy_addr;
	logic        push_en, push_last, emit;
	logic [7:0]  push_byte;
	logic [7:0]  win_rdata;
	logic        win_re;
	logic [15:0] chv;
	logic [OSB-1:0] avail;
	logic [AW:0] addr_wrap;
	logic [3:0][7:0] emit_bytes;
	out_t        emit_d;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = copy_q || !out_free;
	assign acc = in_valid && !in_stall;
	assign go = copy_q && out_free;

	always_comb begin
		ph_n = phase_q;
		err_n = err_q;
		hidx_n = hidx_q;
		hsize_n = hsize_q;
		osize_n = osize_q;
		crem_n = crem_q;
		lrem_n = lrem_q;
		tf_n = tf_q;
		ts_n = ts_q;
		lit_push = 1'b0;
		m_do = 1'b0;
		m_cnt = '0;
		m_off = '0;
		copy_start = 1'b0;
		copy_n = '0;
		chv = '0;
		avail = osize_q - wp_q;
		addr_wrap = '0;
		copy_addr = '0;
		status_emit = 1'b0;
		if (acc) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hidx_q < 4'd8 && in_data.in_byte != magic_byte(hidx_q[2:0])) begin
						ph_n = PH_STOP;
						err_n = ERR_MAGIC;
					end else begin
						if (hidx_q >= HDR_SIZE_BASE) begin
							if (big_q) begin
								hsize_n = {hsize_q[23:0], in_data.in_byte};
							end else begin
								hsize_n = hsize_q
									| ({24'd0, in_data.in_byte} << {hidx_q[1:0], 3'd0});
							end
						end
						if (hidx_q == HDR_LAST) begin
							osize_n = ({1'b0, hsize_n} > SIZE_LIM) ? {OSB{1'b1}}
								: hsize_n[OSB-1:0];
							hidx_n = '0;
							ph_n = PH_CHDR0;
						end else begin
							hidx_n = hidx_q + 4'd1;
						end
					end
				end
				PH_CHDR0: begin
					tf_n = in_data.in_byte;
					ph_n = PH_CHDR1;
				end
				PH_CHDR1: begin
					chv = big_q ? {tf_q, in_data.in_byte} : {in_data.in_byte, tf_q};
					if (chv[15]) begin
						crem_n = 16'd0 - chv;
						ph_n = PH_RAW;
					end else begin
						crem_n = chv;
						ph_n = (chv != 16'd0) ? PH_TOK0 : PH_CHDR0;
					end
				end
				PH_RAW: begin
					if (wp_q < osize_q) begin
						lit_push = 1'b1;
						if (crem_q != 16'd0) crem_n = crem_q - 16'd1;
						if (crem_n == 16'd0) ph_n = PH_CHDR0;
					end else begin
						ph_n = PH_STOP;
						err_n = ERR_OVERFLOW;
					end
				end
				PH_TOK0: begin
					tf_n = in_data.in_byte;
					if (crem_q != 16'd0) crem_n = crem_q - 16'd1;
					if (in_data.in_byte[7]) begin
						ph_n = PH_MATCH1;
					end else begin
						lrem_n = in_data.in_byte + 8'd1;
						ph_n = PH_LIT;
					end
				end
				PH_MATCH1: begin
					ts_n = in_data.in_byte;
					if (crem_q != 16'd0) crem_n = crem_q - 16'd1;
					if (in_data.in_byte[7]) begin
						m_do = 1'b1;
						m_cnt = {5'd0, tf_q[6:4]} + 8'd3;
						m_off = {4'd0, in_data.in_byte[6:0], tf_q[3:0]};
					end else begin
						ph_n = PH_MATCH2;
					end
				end
				PH_MATCH2: begin
					if (crem_q != 16'd0) crem_n = crem_q - 16'd1;
					m_do = 1'b1;
					m_cnt = {1'b0, tf_q[6:0]} + 8'd3;
					m_off = {ts_q[6:0], in_data.in_byte};
				end
				PH_LIT: begin
					if (wp_q < osize_q) begin
						lit_push = 1'b1;
						if (crem_q != 16'd0) crem_n = crem_q - 16'd1;
						lrem_n = lrem_q - 8'd1;
						if (lrem_n == 8'd0) ph_n = (crem_n != 16'd0) ? PH_TOK0 : PH_CHDR0;
					end else begin
						ph_n = PH_STOP;
						err_n = ERR_OVERFLOW;
					end
				end
				default: ph_n = PH_STOP;
			endcase

			if (m_do) begin
				if (OSB'(m_off) > wp_q) begin
					ph_n = PH_STOP;
					err_n = ERR_OFFSET;
				end else begin
					if (avail < OSB'(m_cnt)) begin
						copy_n = avail[7:0];
						ph_n = PH_STOP;
						err_n = ERR_OVERFLOW;
					end else begin
						copy_n = m_cnt;
						ph_n = (crem_n != 16'd0) ? PH_TOK0 : PH_CHDR0;
					end
					copy_start = (copy_n != 8'd0);
					addr_wrap = (wptr_q >= AW'(m_off)) ? {1'b0, wptr_q - AW'(m_off)}
						: {1'b0, wptr_q} + DEPTH_X - (AW + 1)'(m_off);
					copy_addr = addr_wrap[AW-1:0];
				end
			end

			if (ph_n != PH_STOP && in_data.final_byte) begin
				err_n = (ph_n == PH_CHDR0) ? ERR_NONE : ERR_TRUNC;
				ph_n = PH_STOP;
			end
			status_emit = !lit_push && !copy_start && (ph_n == PH_STOP);
		end
	end

	// byte path shared by literals and match copies
	always_comb begin
		push_en = 1'b0;
		push_last = 1'b0;
		push_byte = in_data.in_byte;
		if (lit_push) begin
			push_en = 1'b1;
			push_last = 1'b1;
		end else if (go && rvld_s1) begin
			push_en = 1'b1;
			push_last = (rem_wr_q == 8'd1);
			push_byte = offz_q ? 8'd0 : win_rdata;
		end
		emit_bytes = pack_q;
		emit_bytes[pcnt_q] = push_byte;
		emit = status_emit || (push_en && (push_last || pcnt_q == 2'd3));
		emit_d = '0;
		emit_d.error_code = err_n;
		emit_d.stream_done = (ph_n == PH_STOP);
		emit_d.run_last = 1'b1;
		if (!status_emit) begin
			emit_d.out_byte0 = emit_bytes[0];
			emit_d.out_byte1 = emit_bytes[1];
			emit_d.out_byte2 = emit_bytes[2];
			emit_d.out_byte3 = emit_bytes[3];
			emit_d.byte_count = {1'b0, pcnt_q} + 3'd1;
			emit_d.run_last = push_last;
		end
	end

	assign win_re = go && (rem_rd_q != 8'd0);

	lzcd_window #(.WINDOW_DEPTH(WINDOW_DEPTH), .AW(AW)) u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (push_en),
		.waddr (wptr_q),
		.wdata (push_byte),
		.re    (win_re),
		.raddr (raddr_q),
		.rdata (win_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_q <= 1'b0;
			phase_q <= PH_HEADER;
			err_q <= ERR_NONE;
			hidx_q <= '0;
			hsize_q <= '0;
			osize_q <= '0;
			wp_q <= '0;
			wptr_q <= '0;
			crem_q <= '0;
			lrem_q <= '0;
			tf_q <= '0;
			ts_q <= '0;
			copy_q <= 1'b0;
			rem_rd_q <= '0;
			rem_wr_q <= '0;
			rvld_s1 <= 1'b0;
			pcnt_q <= '0;
			pack_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) big_q <= cfg_wdata;
			phase_q <= ph_n;
			err_q <= err_n;
			hidx_q <= hidx_n;
			hsize_q <= hsize_n;
			osize_q <= osize_n;
			crem_q <= crem_n;
			lrem_q <= lrem_n;
			tf_q <= tf_n;
			ts_q <= ts_n;
			if (push_en) begin
				wp_q <= wp_q + OSB'(1);
				wptr_q <= (wptr_q == LAST_ADDR) ? '0 : wptr_q + AW'(1);
				pcnt_q <= emit ? 2'd0 : pcnt_q + 2'd1;
				if (emit) begin
					pack_q <= '0;
				end else begin
					pack_q[pcnt_q] <= push_byte;
				end
			end
			if (copy_start) begin
				copy_q <= 1'b1;
				rem_rd_q <= copy_n;
				rem_wr_q <= copy_n;
				rvld_s1 <= 1'b0;
			end else if (go) begin
				rvld_s1 <= win_re;
				if (win_re) rem_rd_q <= rem_rd_q - 8'd1;
				if (rvld_s1) begin
					rem_wr_q <= rem_wr_q - 8'd1;
					if (rem_wr_q == 8'd1) copy_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (copy_start) begin
			raddr_q <= copy_addr;
			offz_q <= (m_off == 15'd0);
		end else if (win_re) begin
			raddr_q <= (raddr_q == LAST_ADDR) ? '0 : raddr_q + AW'(1);
		end
		if (emit) out_q <= emit_d;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire
